/* sv/fpp_pkg.sv */
// shared types, constants and decode helpers for the position text parser
// used by fpp_parse, fpp_emit and fen_position_parser
package fpp_pkg;

	localparam int COUNTER_BITS = 16;
	localparam int NUM_PIECES   = 12;
	localparam int NUM_WORDS    = 13;
	localparam int NUM_SQUARES  = 64;
	localparam int CURSOR_W     = 7;
	localparam int WSEL_W       = 4;
	localparam int NUM_FIELDS   = 6;
	localparam int CNT_EXT_W    = COUNTER_BITS + 4;

	localparam logic [COUNTER_BITS-1:0] COUNTER_MAX = {COUNTER_BITS{1'b1}};
	localparam logic [WSEL_W-1:0]       LAST_WORD   = WSEL_W'(NUM_WORDS - 1);
	localparam logic [CURSOR_W-1:0]     CURSOR_END  = CURSOR_W'(NUM_SQUARES);

	// field numbers
	localparam logic [2:0] FLD_BOARD   = 3'd0;
	localparam logic [2:0] FLD_SIDE    = 3'd1;
	localparam logic [2:0] FLD_CASTLE  = 3'd2;
	localparam logic [2:0] FLD_PASSANT = 3'd3;
	localparam logic [2:0] FLD_HALF    = 3'd4;
	localparam logic [2:0] FLD_FULL    = 3'd5;
	localparam logic [2:0] FLD_DONE    = 3'd6;

	// en passant rank codes
	localparam logic [1:0] RANK_NONE  = 2'd0;
	localparam logic [1:0] RANK_SIX   = 2'd1;
	localparam logic [1:0] RANK_THREE = 2'd2;
	localparam logic [1:0] RANK_OTHER = 2'd3;

	// castle flag bits
	localparam int CASTLE_WK = 0;
	localparam int CASTLE_WQ = 1;
	localparam int CASTLE_BK = 2;
	localparam int CASTLE_BQ = 3;

	// characters
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_THREE = 8'h33;
	localparam logic [7:0] CH_SIX   = 8'h36;
	localparam logic [7:0] CH_EIGHT = 8'h38;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_H = 8'h68;
	localparam logic [7:0] CH_LOW_W = 8'h77;

	// board squares of the en passant ranks
	localparam int EP_BASE_SIX   = 16;
	localparam int EP_BASE_THREE = 40;

	typedef logic [COUNTER_BITS-1:0] cnt_t;

	typedef struct packed {
		logic                           hit;
		logic [WSEL_W-1:0]              idx;
	} piece_t;

	// everything one finished text reports
	typedef struct packed {
		logic [NUM_WORDS-1:0][63:0] words;
		logic                       side;
		logic [3:0]                 castle;
		cnt_t                       half;
		cnt_t                       full;
		logic                       err;
	} fpp_snap_t;

	function automatic logic is_sep(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic piece_t piece_index(input logic [7:0] c);
		piece_t p;
		p.hit = 1'b1;
		unique case (c)
			"K":     p.idx = 4'd0;
			"Q":     p.idx = 4'd1;
			"P":     p.idx = 4'd2;
			"R":     p.idx = 4'd3;
			"B":     p.idx = 4'd4;
			"N":     p.idx = 4'd5;
			"k":     p.idx = 4'd6;
			"q":     p.idx = 4'd7;
			"p":     p.idx = 4'd8;
			"r":     p.idx = 4'd9;
			"b":     p.idx = 4'd10;
			"n":     p.idx = 4'd11;
			default: begin
				p.hit = 1'b0;
				p.idx = 4'd0;
			end
		endcase
		return p;
	endfunction

	// v*10 + digit, saturating
	function automatic cnt_t cnt_step(input cnt_t v, input logic [3:0] d);
		logic [CNT_EXT_W-1:0] n;
		n = (CNT_EXT_W'(v) << 3) + (CNT_EXT_W'(v) << 1) + CNT_EXT_W'(d);
		return (n > CNT_EXT_W'(COUNTER_MAX)) ? COUNTER_MAX : n[COUNTER_BITS-1:0];
	endfunction

endpackage

/* sv/fen_position_parser.sv */
// top level of the position text parser: input register, parser, result sequencer
// depends on fpp_pkg, fpp_parse and fpp_emit

// Takes one character per cycle through a registered input stage. Each character
// is decoded and folded into the parser state in the cycle after it is taken, so
// characters stream at one per clock. The character flagged end_of_text closes the
// text: the finished position is copied into the result sequencer, which sends
// thirteen words on consecutive accepted cycles (twelve piece boards, then the en
// passant word with last_word high). The parser is free for the next text at once;
// only a second end_of_text arriving before the previous thirteen words are gone
// holds the input.
module fen_position_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  char_code,
	input  logic                        end_of_text,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [fpp_pkg::WSEL_W-1:0]  word_select,
	output logic [63:0]                 word_bits,
	output logic                        white_to_move,
	output logic [3:0]                  castle_rights,
	output logic [15:0]                 halfmove_clock,
	output logic [15:0]                 fullmove_number,
	output logic                        format_error,
	output logic                        last_word
);

	logic               valid_s1;
	logic [7:0]         char_s1;
	logic               eot_s1;
	logic               go_s1;
	logic               snap_free;
	fpp_pkg::fpp_snap_t snap;

	// end of text waits until the sequencer can take the snapshot
	assign go_s1    = valid_s1 && (!eot_s1 || snap_free);
	assign in_ready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_code;
			eot_s1  <= end_of_text;
		end
	end

	fpp_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (go_s1),
		.char_code   (char_s1),
		.end_of_text (eot_s1),
		.snap        (snap)
	);

	fpp_emit u_emit (
		.clk             (clk),
		.arst_n          (arst_n),
		.load            (go_s1 && eot_s1),
		.snap            (snap),
		.snap_free       (snap_free),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.word_select     (word_select),
		.word_bits       (word_bits),
		.white_to_move   (white_to_move),
		.castle_rights   (castle_rights),
		.halfmove_clock  (halfmove_clock),
		.fullmove_number (fullmove_number),
		.format_error    (format_error),
		.last_word       (last_word)
	);

	property p_stage_holds;
		@(posedge clk) disable iff (!arst_n)
			valid_s1 && !go_s1 |=> valid_s1 && eot_s1 && $stable(char_s1);
	endproperty
	a_stage_holds: assert property (p_stage_holds) else $error("stalled word lost");

	property p_stall_only_eot;
		@(posedge clk) disable iff (!arst_n) valid_s1 && !eot_s1 |-> go_s1;
	endproperty
	a_stall_only_eot: assert property (p_stall_only_eot) else $error("plain character stalled");

	property p_load_shows;
		@(posedge clk) disable iff (!arst_n) go_s1 && eot_s1 |=> out_valid;
	endproperty
	a_load_shows: assert property (p_load_shows) else $error("no words after end of text");

endmodule

/* sv/fpp_parse.sv */
// parser state: field tracking, boards, side, castling, en passant, counters
// depends on fpp_pkg; hands a finished snapshot to fpp_emit at end of text
module fpp_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        char_code,
	input  logic              end_of_text,
	output fpp_pkg::fpp_snap_t snap
);

	logic [2:0]                       field_q, field_d;
	logic                             inside_q, inside_d;
	logic [1:0]                       tcnt_q, tcnt_d;
	logic [fpp_pkg::CURSOR_W-1:0]     cursor_q, cursor_d;
	logic [fpp_pkg::NUM_PIECES-1:0][63:0] boards_q, boards_d;
	logic                             side_q, side_d;
	logic [3:0]                       castle_q, castle_d;
	logic [2:0]                       ep_file_q, ep_file_d;
	logic                             ep_valid_q, ep_valid_d;
	logic [1:0]                       ep_rank_q, ep_rank_d;
	fpp_pkg::cnt_t                    half_q, half_d;
	fpp_pkg::cnt_t                    full_q, full_d;
	logic                             dstop_q, dstop_d;
	logic                             ovf_q, ovf_d;

	logic [1:0]                       tcnt_eff;
	logic                             dstop_eff;
	fpp_pkg::piece_t                  pc;
	logic                             is_digit18, is_digit;
	logic [fpp_pkg::CURSOR_W-1:0]     skip_to;
	logic [3:0]                       fields_seen;
	logic [63:0]                      ep_word;

	always_comb begin
		field_d    = field_q;
		inside_d   = inside_q;
		tcnt_d     = tcnt_q;
		cursor_d   = cursor_q;
		boards_d   = boards_q;
		side_d     = side_q;
		castle_d   = castle_q;
		ep_file_d  = ep_file_q;
		ep_valid_d = ep_valid_q;
		ep_rank_d  = ep_rank_q;
		half_d     = half_q;
		full_d     = full_q;
		dstop_d    = dstop_q;
		ovf_d      = ovf_q;

		tcnt_eff   = inside_q ? tcnt_q : 2'd0;
		dstop_eff  = inside_q ? dstop_q : 1'b0;
		pc         = fpp_pkg::piece_index(char_code);
		is_digit18 = (char_code >= fpp_pkg::CH_ONE) && (char_code <= fpp_pkg::CH_EIGHT);
		is_digit   = (char_code >= fpp_pkg::CH_ZERO) && (char_code <= fpp_pkg::CH_NINE);
		skip_to    = cursor_q + fpp_pkg::CURSOR_W'(char_code[3:0]);

		if (fpp_pkg::is_sep(char_code)) begin
			if (inside_q) begin
				inside_d = 1'b0;
				if (field_q < fpp_pkg::FLD_DONE)
					field_d = field_q + 3'd1;
			end
		end else begin
			inside_d = 1'b1;
			dstop_d  = dstop_eff;
			case (field_q)
				fpp_pkg::FLD_BOARD: begin
					if (pc.hit) begin
						if (cursor_q < fpp_pkg::CURSOR_END) begin
							boards_d[pc.idx][cursor_q[5:0]] = 1'b1;
							cursor_d = cursor_q + 7'd1;
						end else begin
							ovf_d = 1'b1;
						end
					end else if (is_digit18) begin
						if (skip_to > fpp_pkg::CURSOR_END) begin
							ovf_d    = 1'b1;
							cursor_d = fpp_pkg::CURSOR_END;
						end else begin
							cursor_d = skip_to;
						end
					end
				end
				fpp_pkg::FLD_SIDE: begin
					side_d = (tcnt_eff == 2'd0) && (char_code == fpp_pkg::CH_LOW_W);
				end
				fpp_pkg::FLD_CASTLE: begin
					case (char_code)
						"K":     castle_d[fpp_pkg::CASTLE_WK] = 1'b1;
						"Q":     castle_d[fpp_pkg::CASTLE_WQ] = 1'b1;
						"k":     castle_d[fpp_pkg::CASTLE_BK] = 1'b1;
						"q":     castle_d[fpp_pkg::CASTLE_BQ] = 1'b1;
						default: ;
					endcase
				end
				fpp_pkg::FLD_PASSANT: begin
					if (tcnt_eff == 2'd0) begin
						if (char_code >= fpp_pkg::CH_LOW_A && char_code <= fpp_pkg::CH_LOW_H) begin
							ep_file_d  = 3'(char_code - fpp_pkg::CH_LOW_A);
							ep_valid_d = 1'b1;
						end else begin
							ep_file_d  = 3'd0;
							ep_valid_d = 1'b0;
						end
						ep_rank_d = fpp_pkg::RANK_NONE;
					end else if (tcnt_eff == 2'd1) begin
						if (char_code == fpp_pkg::CH_SIX)
							ep_rank_d = fpp_pkg::RANK_SIX;
						else if (char_code == fpp_pkg::CH_THREE)
							ep_rank_d = fpp_pkg::RANK_THREE;
						else
							ep_rank_d = fpp_pkg::RANK_OTHER;
					end else begin
						ep_rank_d = fpp_pkg::RANK_OTHER;
					end
				end
				fpp_pkg::FLD_HALF: begin
					if (!dstop_eff) begin
						if (is_digit)
							half_d = fpp_pkg::cnt_step(half_q, char_code[3:0]);
						else
							dstop_d = 1'b1;
					end
				end
				fpp_pkg::FLD_FULL: begin
					if (!dstop_eff) begin
						if (is_digit)
							full_d = fpp_pkg::cnt_step(full_q, char_code[3:0]);
						else
							dstop_d = 1'b1;
					end
				end
				default: ;
			endcase
			tcnt_d = (tcnt_eff == 2'd3) ? 2'd3 : tcnt_eff + 2'd1;
		end
	end

	// snapshot reflects the state after the final character
	always_comb begin
		ep_word = '0;
		if (ep_valid_d && ep_rank_d == fpp_pkg::RANK_SIX)
			ep_word[6'(fpp_pkg::EP_BASE_SIX) + {3'd0, ep_file_d}] = 1'b1;
		else if (ep_valid_d && ep_rank_d == fpp_pkg::RANK_THREE)
			ep_word[6'(fpp_pkg::EP_BASE_THREE) + {3'd0, ep_file_d}] = 1'b1;
		fields_seen = {1'b0, field_d} + {3'd0, inside_d};
		snap.words  = {ep_word, boards_d};
		snap.side   = side_d;
		snap.castle = castle_d;
		snap.half   = half_d;
		snap.full   = full_d;
		snap.err    = (fields_seen < 4'(fpp_pkg::NUM_FIELDS)) || ovf_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q    <= '0;
			inside_q   <= 1'b0;
			tcnt_q     <= '0;
			cursor_q   <= '0;
			boards_q   <= '0;
			side_q     <= 1'b0;
			castle_q   <= '0;
			ep_file_q  <= '0;
			ep_valid_q <= 1'b0;
			ep_rank_q  <= fpp_pkg::RANK_NONE;
			half_q     <= '0;
			full_q     <= '0;
			dstop_q    <= 1'b0;
			ovf_q      <= 1'b0;
		end else if (step) begin
			if (end_of_text) begin
				// start over for the next text
				field_q    <= '0;
				inside_q   <= 1'b0;
				tcnt_q     <= '0;
				cursor_q   <= '0;
				boards_q   <= '0;
				side_q     <= 1'b0;
				castle_q   <= '0;
				ep_file_q  <= '0;
				ep_valid_q <= 1'b0;
				ep_rank_q  <= fpp_pkg::RANK_NONE;
				half_q     <= '0;
				full_q     <= '0;
				dstop_q    <= 1'b0;
				ovf_q      <= 1'b0;
			end else begin
				field_q    <= field_d;
				inside_q   <= inside_d;
				tcnt_q     <= tcnt_d;
				cursor_q   <= cursor_d;
				boards_q   <= boards_d;
				side_q     <= side_d;
				castle_q   <= castle_d;
				ep_file_q  <= ep_file_d;
				ep_valid_q <= ep_valid_d;
				ep_rank_q  <= ep_rank_d;
				half_q     <= half_d;
				full_q     <= full_d;
				dstop_q    <= dstop_d;
				ovf_q      <= ovf_d;
			end
		end
	end

	property p_cursor_bounded;
		@(posedge clk) disable iff (!arst_n) cursor_q <= fpp_pkg::CURSOR_END;
	endproperty
	a_cursor_bounded: assert property (p_cursor_bounded) else $error("cursor past end");

	property p_eot_clears;
		@(posedge clk) disable iff (!arst_n)
			step && end_of_text |=> field_q == '0 && !inside_q && boards_q == '0;
	endproperty
	a_eot_clears: assert property (p_eot_clears) else $error("state not cleared after text");

	property p_field_sat;
		@(posedge clk) disable iff (!arst_n) field_q <= fpp_pkg::FLD_DONE;
	endproperty
	a_field_sat: assert property (p_field_sat) else $error("field number past six");

endmodule

/* sv/fpp_emit.sv */
// result sequencer: holds one finished snapshot and sends its thirteen words
// depends on fpp_pkg; loaded by fpp_parse's snapshot
module fpp_emit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  fpp_pkg::fpp_snap_t          snap,
	output logic                        snap_free,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [fpp_pkg::WSEL_W-1:0]  word_select,
	output logic [63:0]                 word_bits,
	output logic                        white_to_move,
	output logic [3:0]                  castle_rights,
	output logic [15:0]                 halfmove_clock,
	output logic [15:0]                 fullmove_number,
	output logic                        format_error,
	output logic                        last_word
);

	fpp_pkg::fpp_snap_t          snap_q;
	logic [fpp_pkg::WSEL_W-1:0]  wcnt_q;
	logic                        valid_q;
	logic                        at_last;

	assign at_last   = (wcnt_q == fpp_pkg::LAST_WORD);
	// a new snapshot may land in the cycle the final word leaves
	assign snap_free = !valid_q || (out_ready && at_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			wcnt_q  <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			wcnt_q  <= '0;
		end else if (valid_q && out_ready) begin
			if (at_last)
				valid_q <= 1'b0;
			else
				wcnt_q <= wcnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			snap_q <= snap;
	end

	assign out_valid       = valid_q;
	assign word_select     = wcnt_q;
	assign word_bits       = snap_q.words[wcnt_q];
	assign white_to_move   = snap_q.side;
	assign castle_rights   = snap_q.castle;
	assign halfmove_clock  = 16'(snap_q.half);
	assign fullmove_number = 16'(snap_q.full);
	assign format_error    = snap_q.err;
	assign last_word       = at_last;

	property p_load_starts;
		@(posedge clk) disable iff (!arst_n) load |=> valid_q && wcnt_q == '0;
	endproperty
	a_load_starts: assert property (p_load_starts) else $error("load did not start words");

	property p_load_when_free;
		@(posedge clk) disable iff (!arst_n)
			load |-> !valid_q || (out_ready && at_last);
	endproperty
	a_load_when_free: assert property (p_load_when_free) else $error("snapshot overwritten");

	property p_cnt_range;
		@(posedge clk) disable iff (!arst_n) valid_q |-> wcnt_q <= fpp_pkg::LAST_WORD;
	endproperty
	a_cnt_range: assert property (p_cnt_range) else $error("word count out of range");

	property p_advance;
		@(posedge clk) disable iff (!arst_n)
			valid_q && out_ready && !at_last && !load |=> valid_q && wcnt_q == $past(wcnt_q) + 4'd1;
	endproperty
	a_advance: assert property (p_advance) else $error("word count skipped");

endmodule

/* test/tb_fen_position_parser.sv */
// testbench for fen_position_parser: random and directed position texts, checked word by word
// depends on fpp_pkg and the fen_position_parser rtl
module tb_fen_position_parser;
	timeunit 1ns;
	timeprecision 1ps;

	import fpp_pkg::*;

	localparam int IDLE_LIMIT  = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_AFTER  = 2 * NUM_WORDS;
	localparam int DRAIN       = 20;
	localparam int RANDOM_CHARS = 260;
	localparam logic [8*NUM_PIECES-1:0] PIECE_ORDER = "KQPRBNkqprbn";

	typedef struct packed {
		logic [7:0] c;
		logic       eot;
	} char_item_t;

	typedef struct packed {
		logic [WSEL_W-1:0] sel;
		logic [63:0]       bits;
		logic              side;
		logic [3:0]        castle;
		cnt_t              half;
		cnt_t              full;
		logic              err;
		logic              last;
	} board_word_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [7:0]          char_code = 8'h00;
	logic                end_of_text = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [WSEL_W-1:0]   word_select;
	logic [63:0]         word_bits;
	logic                white_to_move;
	logic [3:0]          castle_rights;
	logic [15:0]         halfmove_clock;
	logic [15:0]         fullmove_number;
	logic                format_error;
	logic                last_word;

	fen_position_parser DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.char_code       (char_code),
		.end_of_text     (end_of_text),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.word_select     (word_select),
		.word_bits       (word_bits),
		.white_to_move   (white_to_move),
		.castle_rights   (castle_rights),
		.halfmove_clock  (halfmove_clock),
		.fullmove_number (fullmove_number),
		.format_error    (format_error),
		.last_word       (last_word)
	);

	char_item_t  char_queue[$];
	logic [7:0]  text_q[$];
	board_word_t expected_words[$];

	int errors      = 0;
	int chars_total = 0;
	int chars_taken = 0;
	int words_got   = 0;
	int texts_done  = 0;
	logic char_taken = 1'b0;

	// position state of the predictor
	logic [2:0]  fld_no;
	logic        in_token;
	logic [1:0]  tok_len;
	logic [6:0]  sq_cur;
	logic [63:0] boards [NUM_PIECES];
	logic        side_w;
	logic [3:0]  castle;
	logic [2:0]  ep_file;
	logic        ep_ok;
	logic [1:0]  ep_rank;
	cnt_t        half_cnt;
	cnt_t        full_cnt;
	logic        digits_off;
	logic        sq_overflow;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	task automatic report(string msg);
		// keep the log short when things go badly wrong
		if (errors < 100)
			$display("ERROR: %s", msg);
		errors++;
	endtask

	task automatic check(int idx, string name, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			report($sformatf("word %0d %s: got %0h, expected %0h", idx, name, got, want));
	endtask

	function automatic int piece_slot(logic [7:0] c);
		int i;
		for (i = 0; i < NUM_PIECES; i++)
			if (PIECE_ORDER[8*(NUM_PIECES-1-i) +: 8] == c)
				return i;
		return -1;
	endfunction

	function automatic logic is_blank(logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic cnt_t next_count(cnt_t v, logic [7:0] c);
		logic [31:0] n;
		n = 32'(v) * 32'd10 + 32'(c - CH_ZERO);
		return (n > 32'(COUNTER_MAX)) ? COUNTER_MAX : cnt_t'(n);
	endfunction

	function automatic logic [63:0] passant_bits();
		if (!ep_ok)
			return 64'd0;
		if (ep_rank == RANK_SIX)
			return 64'd1 << (EP_BASE_SIX + ep_file);
		if (ep_rank == RANK_THREE)
			return 64'd1 << (EP_BASE_THREE + ep_file);
		return 64'd0;
	endfunction

	task automatic clear_position();
		int i;
		fld_no      = FLD_BOARD;
		in_token    = 1'b0;
		tok_len     = 2'd0;
		sq_cur      = '0;
		for (i = 0; i < NUM_PIECES; i++)
			boards[i] = 64'd0;
		side_w      = 1'b0;
		castle      = 4'd0;
		ep_file     = 3'd0;
		ep_ok       = 1'b0;
		ep_rank     = RANK_NONE;
		half_cnt    = '0;
		full_cnt    = '0;
		digits_off  = 1'b0;
		sq_overflow = 1'b0;
	endtask

	task automatic count_digit(inout cnt_t v, input logic [7:0] c);
		if (digits_off)
			return;
		if (c >= CH_ZERO && c <= CH_NINE)
			v = next_count(v, c);
		else
			digits_off = 1'b1;
	endtask

	// fold one accepted character into the position, queue the thirteen words at end of text
	task automatic fold_char(logic [7:0] c, logic eot);
		int slot;
		int nxt_sq;
		int k;
		logic err;
		board_word_t w;
		if (is_blank(c)) begin
			if (in_token) begin
				in_token = 1'b0;
				if (fld_no < FLD_DONE)
					fld_no++;
			end
		end else begin
			if (!in_token) begin
				in_token   = 1'b1;
				tok_len    = 2'd0;
				digits_off = 1'b0;
			end
			case (fld_no)
				FLD_BOARD: begin
					slot = piece_slot(c);
					if (slot >= 0) begin
						if (sq_cur < CURSOR_END) begin
							boards[slot][sq_cur[5:0]] = 1'b1;
							sq_cur++;
						end else begin
							sq_overflow = 1'b1;
						end
					end else if (c >= CH_ONE && c <= CH_EIGHT) begin
						nxt_sq = int'(sq_cur) + int'(c - CH_ZERO);
						if (nxt_sq > NUM_SQUARES) begin
							sq_overflow = 1'b1;
							nxt_sq = NUM_SQUARES;
						end
						sq_cur = CURSOR_W'(nxt_sq);
					end
				end
				FLD_SIDE: side_w = (tok_len == 2'd0 && c == CH_LOW_W);
				FLD_CASTLE: begin
					case (c)
						"K": castle[CASTLE_WK] = 1'b1;
						"Q": castle[CASTLE_WQ] = 1'b1;
						"k": castle[CASTLE_BK] = 1'b1;
						"q": castle[CASTLE_BQ] = 1'b1;
						default: ;
					endcase
				end
				FLD_PASSANT: begin
					if (tok_len == 2'd0) begin
						ep_ok   = (c >= CH_LOW_A && c <= CH_LOW_H);
						ep_file = ep_ok ? 3'(c - CH_LOW_A) : 3'd0;
						ep_rank = RANK_NONE;
					end else if (tok_len == 2'd1) begin
						ep_rank = (c == CH_SIX) ? RANK_SIX :
							(c == CH_THREE) ? RANK_THREE : RANK_OTHER;
					end else begin
						ep_rank = RANK_OTHER;
					end
				end
				FLD_HALF: count_digit(half_cnt, c);
				FLD_FULL: count_digit(full_cnt, c);
				default: ;
			endcase
			if (tok_len != 2'd3)
				tok_len++;
		end
		if (eot) begin
			err = (int'(fld_no) + int'(in_token) < NUM_FIELDS) || sq_overflow;
			for (k = 0; k < NUM_WORDS; k++) begin
				w.sel    = WSEL_W'(k);
				w.bits   = (k < NUM_PIECES) ? boards[k] : passant_bits();
				w.side   = side_w;
				w.castle = castle;
				w.half   = half_cnt;
				w.full   = full_cnt;
				w.err    = err;
				w.last   = (w.sel == LAST_WORD);
				expected_words = {expected_words, w};
			end
			texts_done++;
			clear_position();
		end
	endtask

	// ---------------- stimulus generation ----------------

	function automatic logic [7:0] any_glyph();
		return 8'($urandom_range(33, 126));
	endfunction

	function automatic logic [7:0] any_piece();
		int idx;
		idx = $urandom_range(0, NUM_PIECES - 1);
		return PIECE_ORDER[8*(NUM_PIECES-1-idx) +: 8];
	endfunction

	function automatic logic [7:0] any_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	// append one character to the text being built
	task automatic add_char(logic [7:0] c);
		text_q = {text_q, c};
	endtask

	task automatic put_str(string s);
		int i;
		for (i = 0; i < s.len(); i++)
			add_char(s[i]);
	endtask

	task automatic put_sep();
		int n;
		n = $urandom_range(1, 2);
		repeat (n)
			add_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB + 8'($urandom_range(0, 4)));
	endtask

	// move the text into the driver queue, end_of_text on its last character
	task automatic send_text();
		char_item_t it;
		while (text_q.size() != 0) begin
			it.c   = text_q.pop_front();
			it.eot = (text_q.size() == 0);
			char_queue = {char_queue, it};
		end
	endtask

	task automatic put_count();
		int r;
		int n;
		r = $urandom_range(0, 11);
		if (r == 0)
			add_char(any_glyph());
		n = (r == 1 || r == 2) ? $urandom_range(5, 7) : $urandom_range(1, 3);
		repeat (n)
			add_char(any_digit());
		if (r == 3) begin
			add_char(any_glyph());
			add_char(any_digit());
		end
	endtask

	task automatic put_field(int f);
		int r;
		int n;
		r = $urandom_range(0, 7);
		case (f)
			0: begin
				if (r < 2) begin
					// a run of full ranks, around the end of the board
					n = $urandom_range(7, 9);
					repeat (n)
						add_char(CH_EIGHT);
					if ($urandom_range(0, 1))
						add_char(any_piece());
				end else begin
					n = $urandom_range(1, 14);
					repeat (n) begin
						r = $urandom_range(0, 9);
						if (r < 5)
							add_char(any_piece());
						else if (r < 7)
							add_char(CH_ONE + 8'($urandom_range(0, 7)));
						else if (r == 7)
							add_char(CH_EIGHT);
						else if (r == 8)
							add_char("/");
						else
							add_char($urandom_range(0, 1) ? any_glyph() : CH_NINE);
					end
				end
			end
			1: begin
				if (r < 3)
					add_char(CH_LOW_W);
				else if (r < 5)
					add_char("b");
				else if (r == 5) begin
					add_char(CH_LOW_W);
					add_char(any_glyph());
				end else if (r == 6) begin
					add_char(any_glyph());
					add_char(CH_LOW_W);
				end else
					add_char(any_glyph());
			end
			2: begin
				if (r < 2)
					add_char("-");
				else begin
					n = $urandom_range(1, 4);
					repeat (n)
						add_char(8'(("KQkq" >> (8 * $urandom_range(0, 3))) & 8'hFF));
					if (r == 7)
						add_char(any_glyph());
				end
			end
			3: begin
				if (r < 2)
					add_char("-");
				else begin
					add_char(r == 2 ? any_glyph() : CH_LOW_A + 8'($urandom_range(0, 7)));
					n = $urandom_range(0, 5);
					if (n != 0)
						add_char(n < 3 ? CH_SIX : (n < 5 ? CH_THREE : any_glyph()));
					if (r == 7)
						add_char(any_glyph());
				end
			end
			4, 5: put_count();
			default: begin
				n = $urandom_range(1, 3);
				repeat (n)
					add_char(any_glyph());
			end
		endcase
	endtask

	task automatic gen_text();
		int shape;
		int nfields;
		int n;
		int f;
		shape = $urandom_range(0, 19);
		if (shape < 3) begin
			// raw noise over the whole byte range
			n = $urandom_range(1, 12);
			repeat (n)
				add_char(8'($urandom_range(0, 255)));
		end else begin
			nfields = (shape < 5) ? $urandom_range(1, 5) :
				(shape < 7) ? $urandom_range(7, 8) : NUM_FIELDS;
			if ($urandom_range(0, 7) == 0)
				put_sep();
			for (f = 0; f < nfields; f++) begin
				if (f != 0)
					put_sep();
				put_field(f);
			end
			if ($urandom_range(0, 5) == 0)
				put_sep();
		end
		send_text();
	endtask

	// ---------------- driver, receiver, monitor ----------------

	int burst_left = 0;
	int gap_left   = 0;

	always @(negedge clk) begin : feed
		char_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || char_taken) begin
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (char_queue.size() != 0) begin
				nxt = char_queue.pop_front();
				in_valid    <= 1'b1;
				char_code   <= nxt.c;
				end_of_text <= nxt.eot;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 30);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	int   hold_left = 0;
	logic hold_done = 1'b0;
	logic [8:0] rx_phase = '0;

	always @(negedge clk) begin
		rx_phase++;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (!hold_done && words_got >= HOLD_AFTER) begin
			// long hold-off so the input side backs up
			out_ready <= 1'b0;
			hold_left = HOLD_CYCLES - 1;
			hold_done = 1'b1;
		end else begin
			case (rx_phase[8:7])
				2'd0: out_ready <= 1'b1;
				2'd1: out_ready <= 1'($urandom_range(0, 1));
				2'd2: out_ready <= (rx_phase[1:0] == 2'd0);
				default: out_ready <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	always @(posedge clk) begin : watch
		board_word_t w;
		char_taken <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			fold_char(char_code, end_of_text);
			chars_taken <= chars_taken + 1;
		end
		if (out_valid && out_ready) begin
			words_got <= words_got + 1;
			if (expected_words.size() == 0) begin
				report($sformatf("word %0d arrived with nothing expected", word_select));
			end else begin
				w = expected_words.pop_front();
				check(w.sel, "word_select", word_select, w.sel);
				check(w.sel, "word_bits", word_bits, w.bits);
				check(w.sel, "white_to_move", white_to_move, w.side);
				check(w.sel, "castle_rights", castle_rights, w.castle);
				check(w.sel, "halfmove_clock", halfmove_clock, w.half);
				check(w.sel, "fullmove_number", fullmove_number, w.full);
				check(w.sel, "format_error", format_error, w.err);
				check(w.sel, "last_word", last_word, w.last);
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("timeout: %0d of %0d characters taken, %0d words outstanding",
			chars_taken, chars_total, expected_words.size());
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		clear_position();
		// directed: four separator kinds, saturating clock, rank six square
		put_str("K7k\tw\nQq\ra6 99999 1");
		send_text();
		// byte extremes only, no fields
		add_char(8'hFF);
		add_char(8'h00);
		send_text();
		// board runs off the end, piece dropped, text cut short
		put_str("88888888p b");
		send_text();
		while (char_queue.size() < RANDOM_CHARS)
			gen_text();
		chars_total = char_queue.size();

		@(negedge clk);
		while (chars_taken < chars_total || expected_words.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
		$display("covered %0d texts, %0d characters and %0d result words,",
			texts_done, chars_taken, words_got);
		$display("with random gaps on both sides and one %0d-cycle output hold-off", HOLD_CYCLES);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
